### hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("check failed");
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("check failed");
`endif

### hdl/estp_pkg.sv
package estp_pkg;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic [1:0] K_DATA = 2'd0;
	localparam logic [1:0] K_NAME = 2'd1;
	localparam logic [1:0] K_ID = 2'd2;
	localparam logic [1:0] K_END = 2'd3;

	typedef enum logic [1:0] {
		FK_NONE = 2'd0,
		FK_DATA = 2'd1,
		FK_EVENT = 2'd2,
		FK_ID = 2'd3
	} fkind_t;

	typedef enum logic [4:0] {
		PH_START = 5'b00001,
		PH_COMMENT = 5'b00010,
		PH_FIELD = 5'b00100,
		PH_VFIRST = 5'b01000,
		PH_VALUE = 5'b10000
	} phase_t;

	// one command from front to back
	typedef enum logic [2:0] {
		OP_DATA = 3'd0,
		OP_NAME_CLR = 3'd1,
		OP_NAME_WR = 3'd2,
		OP_ID_CLR = 3'd3,
		OP_ID_WR = 3'd4,
		OP_DISPATCH = 3'd5,
		OP_NOP = 3'd6
	} op_t;

	typedef struct packed {
		op_t op;
		logic [7:0] value;
		logic last;
	} cmd_t;

	function automatic logic [7:0] word_data(input logic [2:0] p);
		unique case (p)
			3'd0: word_data = "d";
			3'd1: word_data = "a";
			3'd2: word_data = "t";
			3'd3: word_data = "a";
			default: word_data = 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] word_event(input logic [2:0] p);
		unique case (p)
			3'd0: word_event = "e";
			3'd1: word_event = "v";
			3'd2: word_event = "e";
			3'd3: word_event = "n";
			3'd4: word_event = "t";
			default: word_event = 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] word_id(input logic [2:0] p);
		unique case (p)
			3'd0: word_id = "i";
			3'd1: word_id = "d";
			default: word_id = 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] word_message(input logic [2:0] p);
		unique case (p)
			3'd0: word_message = "m";
			3'd1: word_message = "e";
			3'd2: word_message = "s";
			3'd3: word_message = "s";
			3'd4: word_message = "a";
			3'd5: word_message = "g";
			3'd6: word_message = "e";
			default: word_message = 8'd0;
		endcase
	endfunction
endpackage

### hdl/estp_front.sv
module estp_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] byte_in,
	output logic cmd_valid,
	input logic cmd_ready,
	output estp_pkg::cmd_t cmd
);
	estp_pkg::phase_t phase_q;
	estp_pkg::fkind_t fk_q;
	logic [2:0] live_q;
	logic [2:0] pos_q;
	logic pcr_q;
	logic dne_q;
	logic crstep_q;
	logic [7:0] cur_q;

	// a byte may need two line steps when a held cr goes first
	logic [7:0] b;
	logic is_lf;
	logic lb_en;
	logic [7:0] lb;
	logic need_two;
	logic final_step;
	estp_pkg::op_t op;
	logic [7:0] val;
	estp_pkg::phase_t ph_n;
	estp_pkg::fkind_t fk_n;
	logic [2:0] live_n;
	logic [2:0] pos_n;
	logic dne_n;
	logic [2:0] fl;
	logic [2:0] fp;
	logic go;

	assign b = crstep_q ? cur_q : byte_in;
	assign is_lf = (b == estp_pkg::CH_LF);
	assign need_two = !crstep_q && pcr_q && !is_lf;
	// a cr after a held cr makes no result in its second step
	assign final_step = !need_two || b == estp_pkg::CH_CR;

	always_comb begin
		fl = live_q;
		fp = pos_q;
		op = estp_pkg::OP_NOP;
		val = 8'd0;
		ph_n = phase_q;
		fk_n = fk_q;
		live_n = live_q;
		pos_n = pos_q;
		dne_n = dne_q;
		lb_en = 1'b0;
		lb = need_two ? estp_pkg::CH_CR : b;
		if (is_lf && !need_two) begin
			if (phase_q == estp_pkg::PH_START) begin
				op = estp_pkg::OP_DISPATCH;
				dne_n = 1'b0;
			end else if (phase_q == estp_pkg::PH_FIELD) begin
				if (live_q[0] && pos_q == 3'd4) begin
					if (dne_q) begin
						op = estp_pkg::OP_DATA;
						val = estp_pkg::CH_LF;
					end
				end else if (live_q[1] && pos_q == 3'd5) begin
					op = estp_pkg::OP_NAME_CLR;
				end else if (live_q[2] && pos_q == 3'd2) begin
					op = estp_pkg::OP_ID_CLR;
				end
			end
			ph_n = estp_pkg::PH_START;
			live_n = 3'b111;
			pos_n = 3'd0;
			fk_n = estp_pkg::FK_NONE;
		end else if (need_two || !(b == estp_pkg::CH_CR)) begin
			lb_en = 1'b1;
		end
		if (lb_en) begin
			if (phase_q == estp_pkg::PH_START) begin
				fl = 3'b111;
				fp = 3'd0;
			end
			unique case (phase_q)
				estp_pkg::PH_START, estp_pkg::PH_FIELD: begin
					if (phase_q == estp_pkg::PH_START && lb == estp_pkg::CH_COLON) begin
						ph_n = estp_pkg::PH_COMMENT;
					end else if (phase_q == estp_pkg::PH_FIELD
						&& lb == estp_pkg::CH_COLON) begin
						ph_n = estp_pkg::PH_VFIRST;
						fk_n = estp_pkg::FK_NONE;
						if (live_q[0] && pos_q == 3'd4) begin
							fk_n = estp_pkg::FK_DATA;
							if (dne_q) begin
								op = estp_pkg::OP_DATA;
								val = estp_pkg::CH_LF;
							end
						end else if (live_q[1] && pos_q == 3'd5) begin
							fk_n = estp_pkg::FK_EVENT;
							op = estp_pkg::OP_NAME_CLR;
						end else if (live_q[2] && pos_q == 3'd2) begin
							fk_n = estp_pkg::FK_ID;
							op = estp_pkg::OP_ID_CLR;
						end
					end else begin
						ph_n = estp_pkg::PH_FIELD;
						live_n[0] = fl[0] && fp < 3'd4 && estp_pkg::word_data(fp) == lb;
						live_n[1] = fl[1] && fp < 3'd5 && estp_pkg::word_event(fp) == lb;
						live_n[2] = fl[2] && fp < 3'd2 && estp_pkg::word_id(fp) == lb;
						pos_n = (fp < 3'd7) ? fp + 3'd1 : fp;
					end
				end
				estp_pkg::PH_VFIRST, estp_pkg::PH_VALUE: begin
					ph_n = estp_pkg::PH_VALUE;
					if (phase_q == estp_pkg::PH_VALUE || lb != estp_pkg::CH_SPACE) begin
						val = lb;
						unique case (fk_q)
							estp_pkg::FK_DATA: begin
								op = estp_pkg::OP_DATA;
								dne_n = 1'b1;
							end
							estp_pkg::FK_EVENT: op = estp_pkg::OP_NAME_WR;
							estp_pkg::FK_ID: op = estp_pkg::OP_ID_WR;
							default: op = estp_pkg::OP_NOP;
						endcase
					end
				end
				default: ph_n = phase_q;
			endcase
		end
	end

	// every step pushes one command; the last one carries the end of the item
	assign cmd_valid = in_valid || crstep_q;
	assign go = cmd_valid && cmd_ready;
	assign in_ready = cmd_ready && !crstep_q;
	assign cmd.op = op;
	assign cmd.value = val;
	assign cmd.last = final_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= estp_pkg::PH_START;
			fk_q <= estp_pkg::FK_NONE;
			live_q <= 3'b111;
			pos_q <= 3'd0;
			pcr_q <= 1'b0;
			dne_q <= 1'b0;
			crstep_q <= 1'b0;
		end else if (go) begin
			phase_q <= ph_n;
			fk_q <= fk_n;
			live_q <= live_n;
			pos_q <= pos_n;
			dne_q <= dne_n;
			if (need_two) begin
				crstep_q <= 1'b1;
				pcr_q <= 1'b0;
			end else begin
				crstep_q <= 1'b0;
				if (is_lf) pcr_q <= 1'b0;
				else if (b == estp_pkg::CH_CR) pcr_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && need_two) cur_q <= byte_in;
	end
endmodule

### hdl/estp_queue.sv
module estp_queue #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input estp_pkg::cmd_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output estp_pkg::cmd_t rd_data
);
	localparam int AW = $clog2(DEPTH);
	estp_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0] cnt_q;
	logic wr;
	logic rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

### hdl/estp_back.sv
module estp_back #(
	parameter int NAME_MAX = 16,
	parameter int ID_MAX = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input estp_pkg::cmd_t cmd,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] byte_value,
	output logic name_is_default,
	output logic name_cut,
	output logic id_cut,
	output logic last_of_run
);
	localparam int NW = $clog2(NAME_MAX + 1);
	localparam int IW = $clog2(ID_MAX + 1);
	localparam int NA = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
	localparam int IA = (ID_MAX > 1) ? $clog2(ID_MAX) : 1;

	typedef enum logic [2:0] {
		B_CMD = 3'b001,
		B_NAME = 3'b010,
		B_ID = 3'b100
	} bst_t;

	logic [7:0] nmem_q [NAME_MAX];
	logic [7:0] imem_q [ID_MAX];
	logic [NW-1:0] nlen_q;
	logic [IW-1:0] ilen_q;
	logic ndef_q;
	logic nov_q;
	logic iov_q;
	logic [6:0] msg_q;
	bst_t st_q;
	logic [NW-1:0] ni_q;
	logic [IW-1:0] ii_q;
	logic def_q;
	logic lastcmd_q;
	logic dne_q;

	logic ov_q;
	logic [1:0] k_q;
	logic [7:0] v_q;
	logic d_q;
	logic nc_q;
	logic ic_q;
	logic l_q;

	logic slot;
	logic take;
	logic msg;
	logic dflt;
	logic load;

	assign slot = !ov_q || out_ready;
	assign cmd_ready = slot && st_q == B_CMD;
	assign take = cmd_valid && cmd_ready;
	assign msg = ndef_q || (!nov_q && nlen_q == NW'(7) && msg_q == 7'h7f);
	assign dflt = msg || nlen_q == '0;
	assign load = (take && cmd.op == estp_pkg::OP_DATA)
		|| (st_q == B_NAME && slot && ni_q < nlen_q)
		|| (st_q == B_ID && slot);

	assign out_valid = ov_q;
	assign kind = k_q;
	assign byte_value = v_q;
	assign name_is_default = d_q;
	assign name_cut = nc_q;
	assign id_cut = ic_q;
	assign last_of_run = l_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nlen_q <= '0;
			ilen_q <= '0;
			ndef_q <= 1'b1;
			nov_q <= 1'b0;
			iov_q <= 1'b0;
			msg_q <= '0;
			st_q <= B_CMD;
			ni_q <= '0;
			ii_q <= '0;
			def_q <= 1'b0;
			lastcmd_q <= 1'b0;
			ov_q <= 1'b0;
			dne_q <= 1'b0;
		end else begin
			ov_q <= load || (ov_q && !out_ready);
			unique case (st_q)
				B_CMD: begin
					if (take) begin
						unique case (cmd.op)
							estp_pkg::OP_DATA: begin
								dne_q <= 1'b1;
							end
							estp_pkg::OP_NAME_CLR: begin
								ndef_q <= 1'b0;
								nlen_q <= '0;
								nov_q <= 1'b0;
								msg_q <= '0;
							end
							estp_pkg::OP_NAME_WR: begin
								if (nlen_q < NW'(NAME_MAX)) begin
									nlen_q <= nlen_q + 1'b1;
									if (nlen_q < NW'(7))
										msg_q[nlen_q[2:0]] <= cmd.value ==
											estp_pkg::word_message(nlen_q[2:0]);
								end else begin
									nov_q <= 1'b1;
								end
							end
							estp_pkg::OP_ID_CLR: begin
								ilen_q <= '0;
								iov_q <= 1'b0;
							end
							estp_pkg::OP_ID_WR: begin
								if (ilen_q < IW'(ID_MAX)) ilen_q <= ilen_q + 1'b1;
								else iov_q <= 1'b1;
							end
							estp_pkg::OP_DISPATCH: begin
								if (dne_q || !msg) begin
									def_q <= dflt;
									lastcmd_q <= cmd.last;
									ni_q <= '0;
									ii_q <= '0;
									st_q <= (!dflt) ? B_NAME : B_ID;
								end else begin
									ndef_q <= 1'b1;
									nlen_q <= '0;
									nov_q <= 1'b0;
									dne_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				B_NAME: begin
					if (slot) begin
						if (ni_q < nlen_q) begin
							ni_q <= ni_q + 1'b1;
						end else begin
							st_q <= B_ID;
						end
					end
				end
				B_ID: begin
					if (slot) begin
						if (ii_q < ilen_q) begin
							ii_q <= ii_q + 1'b1;
						end else begin
							st_q <= B_CMD;
							ndef_q <= 1'b1;
							nlen_q <= '0;
							nov_q <= 1'b0;
							dne_q <= 1'b0;
						end
					end
				end
				default: st_q <= B_CMD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && cmd.op == estp_pkg::OP_NAME_WR && nlen_q < NW'(NAME_MAX))
			nmem_q[nlen_q[NA-1:0]] <= cmd.value;
		if (take && cmd.op == estp_pkg::OP_ID_WR && ilen_q < IW'(ID_MAX))
			imem_q[ilen_q[IA-1:0]] <= cmd.value;
		if (st_q == B_CMD && take && cmd.op == estp_pkg::OP_DATA) begin
			k_q <= estp_pkg::K_DATA;
			v_q <= cmd.value;
			d_q <= 1'b0;
			nc_q <= 1'b0;
			ic_q <= 1'b0;
			l_q <= cmd.last;
		end else if (st_q == B_NAME && slot && ni_q < nlen_q) begin
			k_q <= estp_pkg::K_NAME;
			v_q <= nmem_q[ni_q[NA-1:0]];
			d_q <= 1'b0;
			nc_q <= 1'b0;
			ic_q <= 1'b0;
			l_q <= 1'b0;
		end else if (st_q == B_ID && slot) begin
			if (ii_q < ilen_q) begin
				k_q <= estp_pkg::K_ID;
				v_q <= imem_q[ii_q[IA-1:0]];
				d_q <= 1'b0;
				nc_q <= 1'b0;
				ic_q <= 1'b0;
				l_q <= 1'b0;
			end else begin
				k_q <= estp_pkg::K_END;
				v_q <= 8'd0;
				d_q <= def_q;
				nc_q <= !def_q && nov_q;
				ic_q <= iov_q;
				l_q <= lastcmd_q;
			end
		end
	end
endmodule

### hdl/event_stream_text_parser.sv
// Byte-stream event parser. One byte enters per cycle while in_ready is high,
// through a front stage that classifies it and pushes a command into a four-entry
// queue; a back stage runs the commands and drives a registered result. A held CR
// followed by a non-LF byte gets its own front step before that byte. An emitted
// dispatch blocks the back stage while it reads the name store, then the id store
// (only the id store for a default name), so input stalls once the queue fills.
module event_stream_text_parser #(
	parameter int NAME_MAX = 16,
	parameter int ID_MAX = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] byte_in,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] byte_value,
	output logic name_is_default,
	output logic name_cut,
	output logic id_cut,
	output logic last_of_run
);
	logic f_valid;
	logic f_ready;
	estp_pkg::cmd_t f_cmd;
	logic q_valid;
	logic q_ready;
	estp_pkg::cmd_t q_cmd;

	estp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .byte_in(byte_in),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	estp_queue #(.DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
	);

	estp_back #(.NAME_MAX(NAME_MAX), .ID_MAX(ID_MAX)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .byte_value(byte_value), .name_is_default(name_is_default),
		.name_cut(name_cut), .id_cut(id_cut), .last_of_run(last_of_run)
	);
endmodule

### hdl/estp_checker.sv
`include "assert_macros.svh"
module estp_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] kind,
	input logic [7:0] byte_value,
	input logic name_is_default,
	input logic name_cut,
	input logic last_of_run
);
	`CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(byte_value))
	`CHK_IMPL(a_endzero, out_valid && kind == estp_pkg::K_END, byte_value == 8'd0)
	`CHK_IMPL(a_cutdef, out_valid && name_is_default, !name_cut)
	`CHK_IMPL(a_lastkind, out_valid && last_of_run,
		kind == estp_pkg::K_DATA || kind == estp_pkg::K_END)
endmodule

bind event_stream_text_parser estp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.kind(kind), .byte_value(byte_value), .name_is_default(name_is_default),
	.name_cut(name_cut), .last_of_run(last_of_run)
);
